>>> rtl/tdpf_pkg.sv
// ----------------------------------------------------------------------------
// tdpf_pkg
// Types and constants for the trial division prime filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpf_pkg;

  // width of the candidate and found prime fields on the stream ports
  localparam int unsigned FIELD_BITS = 16;

  // smallest value that can be a prime
  localparam int unsigned MIN_PRIME = 2;

  // control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_EMIT
  } tdpf_state_t;

endpackage : tdpf_pkg

`default_nettype wire

>>> rtl/trial_division_prime_filter.sv
// ----------------------------------------------------------------------------
// trial_division_prime_filter
// Each input beat is taken in idle; values below two are dropped there. The
// stored primes are then read from the table in turn and each divides the
// candidate with one remainder bit per cycle; a zero remainder drops it, else it
// is emitted. No new beat is taken until idle; a stalled output holds the sequencer in emit.
// Reset: prime count and handshakes cleared; the table needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_filter #(
  parameter int unsigned MAX_PRIMES = 64,
  parameter int unsigned VALUE_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst,
  // input stream
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire [tdpf_pkg::FIELD_BITS-1:0]    s_axis_tdata,   // [15:0] candidate
  input  wire                               s_axis_tuser,   // [0] run_start
  // output stream
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [tdpf_pkg::FIELD_BITS-1:0]   m_axis_tdata,   // [15:0] found_prime
  output logic                              m_axis_tuser    // [0] not_stored
);

  import tdpf_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PRIMES + 1);
  localparam int unsigned IDX_W = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int unsigned BIT_W = $clog2(VALUE_BITS);

  // prime table memory
  logic [VALUE_BITS-1:0] prime_table [MAX_PRIMES];
  logic [VALUE_BITS-1:0] rd_data;

  tdpf_state_t           state;
  tdpf_state_t           state_next;

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      idx;
  logic [VALUE_BITS-1:0] cand;
  logic [VALUE_BITS-1:0] divisor;
  logic [VALUE_BITS-1:0] dividend;
  logic [VALUE_BITS-1:0] rem;
  logic [BIT_W-1:0]      bit_cnt;

  logic                  in_beat;
  logic                  out_beat;
  logic [VALUE_BITS-1:0] cand_in;
  logic [CNT_W-1:0]      count_eff;
  logic                  cand_small;
  logic                  table_full;
  logic                  div_last;
  logic                  rem_zero;
  logic [CNT_W-1:0]      idx_inc;
  logic                  out_free;

  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;

  logic [VALUE_BITS:0]   rem_shift;
  logic                  rem_ge;
  logic [VALUE_BITS-1:0] rem_step;

  // handshake and decode
  assign in_beat    = s_axis_tvalid && s_axis_tready;
  assign out_beat   = m_axis_tvalid && m_axis_tready;
  assign cand_in    = VALUE_BITS'(s_axis_tdata);
  assign count_eff  = s_axis_tuser ? '0 : count;
  assign cand_small = cand_in < VALUE_BITS'(MIN_PRIME);
  assign table_full = count == CNT_W'(MAX_PRIMES);
  assign div_last   = bit_cnt == BIT_W'(VALUE_BITS - 1);
  assign idx_inc    = idx + CNT_W'(1);
  assign out_free   = !m_axis_tvalid || m_axis_tready;

  // one restoring remainder step
  assign rem_shift = {rem, dividend[VALUE_BITS-1]};
  assign rem_ge    = rem_shift >= {1'b0, divisor};
  assign rem_step  = rem_ge ? VALUE_BITS'(rem_shift - {1'b0, divisor})
                            : rem_shift[VALUE_BITS-1:0];
  assign rem_zero  = rem_step == '0;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory control
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && !cand_small) begin
          if (count_eff == '0) begin
            state_next = S_EMIT;
          end else begin
            rd_en      = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_last) begin
          if (rem_zero) begin
            state_next = S_IDLE;
          end else if (idx_inc == count) begin
            state_next = S_EMIT;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = idx_inc[IDX_W-1:0];
            state_next = S_READ;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          wr_en      = !table_full;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      prime_table[count[IDX_W-1:0]] <= cand;
    end
    if (rd_en) begin
      rd_data <= prime_table[rd_addr];
    end
  end

  // prime count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_beat && s_axis_tuser) begin
      count <= '0;
    end else if (wr_en) begin
      count <= count + CNT_W'(1);
    end
  end

  // candidate, index and remainder datapath
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cand <= cand_in;
      idx  <= '0;
    end
    if (state == S_READ) begin
      divisor  <= rd_data;
      dividend <= cand;
      rem      <= '0;
      bit_cnt  <= '0;
    end
    if (state == S_DIV) begin
      rem      <= rem_step;
      dividend <= dividend << 1;
      bit_cnt  <= bit_cnt + BIT_W'(1);
      if (div_last) begin
        idx <= idx_inc;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (out_beat) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      m_axis_tdata <= FIELD_BITS'(cand);
      m_axis_tuser <= table_full;
    end
  end

`ifndef SYNTHESIS
  // the count never runs past the table size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_PRIMES))
    else $error("prime count exceeds table size");

  // every table read during the walk is below the stored count
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_DIV) |-> idx < count)
    else $error("table walk beyond stored primes");

  // a divisible candidate leaves the table untouched and returns to idle
  a_reject: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_last && rem_zero) |=> state == S_IDLE && $stable(count))
    else $error("rejected candidate changed the table");

  // a table write only happens with room left
  a_write_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> count < CNT_W'(MAX_PRIMES))
    else $error("write into a full table");
`endif

endmodule : trial_division_prime_filter

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trial division prime filter. Candidate beats go
// in through the input stream with random gaps. A local sieve tracks the table
// of stored primes and predicts each found prime and its not-stored flag.
// Output beats are compared in order against the predictions. The receiver
// stalls at random and holds off once for a long stretch, so the block backs
// up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tdpf_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 64;
  localparam int unsigned HOLD_CYCLES  = 4000;
  localparam int unsigned DRAIN_CYCLES = 1200;
  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned TARGET_CANDS = 580;
  localparam int unsigned MAX_REPORTS  = 40;

  typedef struct packed {
    logic                  run_start;
    logic [FIELD_BITS-1:0] value;
  } cand_beat_t;

  typedef struct packed {
    logic                  not_stored;
    logic [FIELD_BITS-1:0] prime;
  } prime_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [FIELD_BITS-1:0] s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [FIELD_BITS-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  trial_division_prime_filter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // sieve state mirrored on the bench side
  logic [FIELD_BITS-1:0] sieve_primes [TABLE_DEPTH];
  int unsigned           sieve_count = 0;

  cand_beat_t  cands_pending [$];
  prime_beat_t primes_due [$];

  int unsigned n_cands_in   = 0;
  int unsigned n_runs       = 0;
  int unsigned n_primes_out = 0;
  int unsigned n_not_stored = 0;
  int unsigned n_errors     = 0;
  int unsigned n_cycles     = 0;
  int unsigned in_gap       = 0;
  int unsigned out_stall    = 0;
  logic        in_fire      = 1'b0;
  logic        hold_off     = 1'b0;

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // reset, once
  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
  end

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // next state of the sieve for one accepted candidate
  function automatic void sieve_next(input cand_beat_t c, output bit emit,
                                     output prime_beat_t res);
    int unsigned k;
    emit = 1'b0;
    res  = '0;
    if (c.run_start)
      sieve_count = 0;
    if (c.value < MIN_PRIME)
      return;
    for (k = 0; k < sieve_count; k++)
      if ((c.value % sieve_primes[k]) == 0)
        return;
    emit = 1'b1;
    res.prime = c.value;
    if (sieve_count < TABLE_DEPTH) begin
      sieve_primes[sieve_count] = c.value;
      sieve_count++;
      res.not_stored = 1'b0;
    end else begin
      res.not_stored = 1'b1;
    end
  endfunction

  // sender gaps: mostly none or short, a few long, some stretches with none
  function automatic int unsigned pick_gap();
    if (((n_cands_in / 48) % 4) == 3)
      return 0;
    if ($urandom_range(0, 9) < 6)
      return 0;
    if ($urandom_range(0, 9) < 8)
      return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  // receiver stalls, same shape, windows keyed on results
  function automatic int unsigned pick_stall();
    if (((n_primes_out / 16) % 4) == 1)
      return 0;
    if ($urandom_range(0, 9) < 6)
      return 0;
    if ($urandom_range(0, 9) < 8)
      return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  task automatic push_cand(input int unsigned value, input bit start);
    cand_beat_t c;
    c.value     = value[FIELD_BITS-1:0];
    c.run_start = start;
    cands_pending.push_back(c);
  endtask

  // well-formed run: start flag on the first beat, then ascending numbers
  task automatic push_run(input int unsigned base, input int unsigned len);
    int unsigned k;
    for (k = 0; k < len; k++)
      push_cand(base + k, k == 0);
  endtask

  // input driver, changes at the falling edge
  always @(negedge clk) begin : drive_cands
    cand_beat_t c;
    if (!rst && (!s_axis_tvalid || in_fire)) begin
      if (in_gap != 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (cands_pending.size() != 0) begin
        c = cands_pending.pop_front();
        s_axis_tdata  <= c.value;
        s_axis_tuser  <= c.run_start;
        s_axis_tvalid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready, random stalls plus the long hold-off
  always @(negedge clk) begin : drive_ready
    if (rst || hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (out_stall != 0) begin
      out_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      out_stall = pick_stall();
    end
  end

  // one long receiver hold-off once results are flowing
  initial begin : long_hold
    wait (n_primes_out >= 40);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off <= 1'b0;
  end

  // monitor: check output beats first, then predict from the input beat
  always @(posedge clk) begin : watch_streams
    cand_beat_t  got_cand;
    prime_beat_t want;
    bit          emit;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (primes_due.size() == 0) begin
          report_mismatch($sformatf("unexpected beat %0d not_stored %0b",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          want = primes_due.pop_front();
          if (m_axis_tdata !== want.prime)
            report_mismatch($sformatf("found_prime got %0d want %0d",
                                      m_axis_tdata, want.prime));
          if (m_axis_tuser !== want.not_stored)
            report_mismatch($sformatf("not_stored got %0b want %0b for %0d",
                                      m_axis_tuser, want.not_stored, want.prime));
          if (want.not_stored)
            n_not_stored++;
        end
        n_primes_out++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        got_cand.value     = s_axis_tdata;
        got_cand.run_start = s_axis_tuser;
        sieve_next(got_cand, emit, want);
        if (emit)
          primes_due.push_back(want);
        if (got_cand.run_start)
          n_runs++;
        n_cands_in++;
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (n_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      n_cycles++;
    end
    $display("timeout after %0d cycles, %0d primes still due", n_cycles,
             primes_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus and end of run
  initial begin : stimulus
    int unsigned total;
    int unsigned kind;
    int unsigned fills;
    int unsigned len;

    // directed: extremes, values below two, divisible, composites on empty table
    push_cand(2, 1'b1);
    push_cand(0, 1'b0);
    push_cand(1, 1'b0);
    push_cand(3, 1'b0);
    push_cand(4, 1'b0);
    push_cand(9, 1'b0);
    push_cand(65535, 1'b0);
    push_cand(65521, 1'b0);
    push_cand(0, 1'b1);
    push_cand(65535, 1'b0);
    push_cand(1, 1'b1);
    push_cand(4, 1'b0);
    push_cand(8, 1'b0);
    push_cand(35, 1'b0);
    push_cand(32768, 1'b0);
    push_cand(21845, 1'b1);
    push_cand(43690, 1'b0);

    // primes from two past the 64th, so the last few come out not kept
    push_run(2, 320);

    // random mix of runs, table-filling runs and noise
    fills = 0;
    total = cands_pending.size();
    while (total < TARGET_CANDS) begin
      kind = $urandom_range(0, 9);
      if (kind == 6 && fills < 2) begin
        // high base: every survivor is stored until the table is full
        len = $urandom_range(66, 80);
        push_run($urandom_range(32768, 65535 - len), len);
        fills++;
      end else if (kind <= 6) begin
        len = $urandom_range(3, 30);
        if ($urandom_range(0, 1) == 0)
          push_run(2, len);
        else
          push_run($urandom_range(0, 65535 - len), len);
      end else begin
        if ($urandom_range(0, 7) == 0)
          push_cand($urandom_range(0, 1), $urandom_range(0, 3) == 0);
        else
          push_cand($urandom_range(0, 65535), $urandom_range(0, 3) == 0);
      end
      total = cands_pending.size();
    end

    // wait for every beat to be taken and every prime to arrive
    while (cands_pending.size() != 0 || s_axis_tvalid)
      @(posedge clk);
    while (primes_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (primes_due.size() != 0)
      report_mismatch($sformatf("%0d primes never arrived", primes_due.size()));

    $display("run covered %0d candidates over %0d table restarts", n_cands_in, n_runs);
    $display("checked %0d found primes, %0d of them flagged as not kept",
             n_primes_out, n_not_stored);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : tb_top

`default_nettype wire
